[hdl/box_average_image_scaler_top_defines.svh]
// Assertion macros shared by the scaler checker.
`ifndef BOX_AVERAGE_IMAGE_SCALER_TOP_DEFINES_SVH
`define BOX_AVERAGE_IMAGE_SCALER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scaler check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scaler check failed");

`endif

[hdl/bas_pkg.sv]
// Shared constants, command/status types and helpers of the box-average scaler.
package bas_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_ENLARGE = 8;

  localparam int DIM_W     = 13;
  localparam int POS_W     = 12;
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [PIX_W-1:0] ALPHA_FULL = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rinit;
    logic col_rd;
    logic col_wr;
    logic row_adv;
    logic em_rd;
    logic q_start;
    logic q_step;
    logic k_inc;
    logic out_pix;
    logic out_err;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic ratio_ok;
    logic div_done;
    logic col_ok;
    logic col_fin;
    logic row_go;
    logic has_fin;
    logic k_last;
    logic q_done;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [DIM_W-1:0] raw;
    logic [DIM_W-1:0] rem;
  } dda_t;

  // Advance floor(i*S/D) to i+1, given q = S/D and r = S mod D.
  function automatic dda_t dda_step(input dda_t cur, input logic [DIM_W-1:0] q,
                                    input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] d);
    logic [DIM_W:0] sum;
    logic           carry;
    dda_t           nxt;
    sum     = {1'b0, cur.rem} + {1'b0, r};
    carry   = (sum >= {1'b0, d});
    nxt.rem = carry ? DIM_W'(sum - {1'b0, d}) : sum[DIM_W-1:0];
    nxt.raw = cur.raw + q + {{(DIM_W-1){1'b0}}, carry};
    return nxt;
  endfunction

endpackage

[hdl/bas_ctrl.sv]
// Sequencer of the box-average scaler: walks columns, rows and result emission.
module bas_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bas_pkg::status_t sts_i,
  output bas_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_RINIT = 4'd2;
  localparam logic [3:0] S_COL   = 4'd3;
  localparam logic [3:0] S_CWR   = 4'd4;
  localparam logic [3:0] S_ROW   = 4'd5;
  localparam logic [3:0] S_ERD   = 4'd6;
  localparam logic [3:0] S_EPREP = 4'd7;
  localparam logic [3:0] S_EDIV  = 4'd8;
  localparam logic [3:0] S_EOUT  = 4'd9;
  localparam logic [3:0] S_ERR   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.bad) state_d = S_ERR;
          else if (sts_i.ratio_ok) state_d = S_RINIT;
          else state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.rinit = 1'b1;
        state_d     = S_COL;
      end
      S_COL: begin
        if (sts_i.col_ok) begin
          cmd_o.col_rd = 1'b1;
          state_d      = S_CWR;
        end else begin
          state_d = S_ROW;
        end
      end
      S_CWR: begin
        cmd_o.col_wr = 1'b1;
        state_d      = sts_i.col_fin ? S_COL : S_ROW;
      end
      S_ROW: begin
        if (!sts_i.row_go) state_d = S_FIN;
        else if (sts_i.has_fin) state_d = S_ERD;
        else cmd_o.row_adv = 1'b1;
      end
      S_ERD: begin
        cmd_o.em_rd = 1'b1;
        state_d     = S_EPREP;
      end
      S_EPREP: begin
        cmd_o.q_start = 1'b1;
        state_d       = S_EDIV;
      end
      S_EDIV: begin
        cmd_o.q_step = 1'b1;
        if (sts_i.q_done) state_d = S_EOUT;
      end
      S_EOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_pix = 1'b1;
          if (sts_i.k_last) begin
            cmd_o.row_adv = 1'b1;
            state_d       = S_ROW;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = S_ERD;
          end
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.out_err = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

[hdl/bas_dp.sv]
// Datapath of the box-average scaler: config, position tracking, sums memory,
// ratio and average dividers, result register.
module bas_dp #(
  parameter int MAX_WIDTH   = bas_pkg::MAX_WIDTH,
  parameter int MAX_ENLARGE = bas_pkg::MAX_ENLARGE
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bas_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bas_pkg::DIM_W-1:0]          cfg_data_i,
  input  logic [bas_pkg::PIX_W-1:0]          red_in_i,
  input  logic [bas_pkg::PIX_W-1:0]          green_in_i,
  input  logic [bas_pkg::PIX_W-1:0]          blue_in_i,
  input  bas_pkg::cmd_t                      cmd_i,
  output bas_pkg::status_t                   sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bas_pkg::POS_W-1:0]          dst_x_o,
  output logic [bas_pkg::POS_W-1:0]          dst_y_o,
  output logic [bas_pkg::PIX_W-1:0]          red_out_o,
  output logic [bas_pkg::PIX_W-1:0]          green_out_o,
  output logic [bas_pkg::PIX_W-1:0]          blue_out_o,
  output logic [bas_pkg::PIX_W-1:0]          alpha_out_o,
  output logic                               last_o,
  output logic                               config_error_o
);

  localparam int DW  = bas_pkg::DIM_W;
  localparam int PW  = bas_pkg::PIX_W;
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int NW  = $clog2(MAX_ENLARGE + 1);
  localparam int KW  = (MAX_ENLARGE > 1) ? $clog2(MAX_ENLARGE) : 1;
  localparam int CW  = 2 * DW;
  localparam int NMW = CW + PW;

  // Configuration
  logic [DW-1:0] sw_q, sh_q, dw_q, dh_q;
  logic          cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_index_i == bas_pkg::CFG_SRC_WIDTH ||
                   cfg_index_i == bas_pkg::CFG_SRC_HEIGHT ||
                   cfg_index_i == bas_pkg::CFG_DST_WIDTH ||
                   cfg_index_i == bas_pkg::CFG_DST_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= DW'(1);
      sh_q <= DW'(1);
      dw_q <= DW'(1);
      dh_q <= DW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bas_pkg::CFG_SRC_WIDTH:  sw_q <= cfg_data_i;
        bas_pkg::CFG_SRC_HEIGHT: sh_q <= cfg_data_i;
        bas_pkg::CFG_DST_WIDTH:  dw_q <= cfg_data_i;
        bas_pkg::CFG_DST_HEIGHT: dh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DW+4:0] lim_w, lim_h;
  logic          bad;
  assign lim_w = (DW+5)'(sw_q) * (DW+5)'(MAX_ENLARGE);
  assign lim_h = (DW+5)'(sh_q) * (DW+5)'(MAX_ENLARGE);
  assign bad = (sw_q == '0) || (sh_q == '0) || (dw_q == '0) || (dh_q == '0) ||
               ({2'b0, sw_q} > 15'(MAX_WIDTH)) || ({2'b0, dw_q} > 15'(MAX_WIDTH)) ||
               ({2'b0, sh_q} > 15'(bas_pkg::MAX_HEIGHT)) ||
               ({2'b0, dh_q} > 15'(bas_pkg::MAX_HEIGHT)) ||
               ((DW+5)'(dw_q) > lim_w) || ((DW+5)'(dh_q) > lim_h);

  // Ratio divider: lane 0 columns (S/D), lane 1 rows, one bit per cycle
  logic [DW-1:0] rn_q [2];
  logic [DW-1:0] rr_q [2];
  logic [DW-1:0] rqo_q [2];
  logic [3:0]    rcnt_q;
  logic          ratio_ok_q;
  logic          div_done;
  logic [DW-1:0] rden [2];
  logic [DW-1:0] rnum [2];
  assign rden[0] = dw_q;
  assign rden[1] = dh_q;
  assign rnum[0] = sw_q;
  assign rnum[1] = sh_q;
  assign div_done = cmd_i.div_step && (rcnt_q == 4'(DW - 1));

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      logic [DW:0] t;
      t = {rr_q[l], rn_q[l][DW-1]};
      // Keep a finished ratio until the sizes change
      if (cmd_i.load && !ratio_ok_q) begin
        rn_q[l]  <= rnum[l];
        rr_q[l]  <= '0;
        rqo_q[l] <= '0;
      end else if (cmd_i.div_step) begin
        rn_q[l] <= {rn_q[l][DW-2:0], 1'b0};
        if (t >= {1'b0, rden[l]}) begin
          rr_q[l]  <= DW'(t - {1'b0, rden[l]});
          rqo_q[l] <= {rqo_q[l][DW-2:0], 1'b1};
        end else begin
          rr_q[l]  <= t[DW-1:0];
          rqo_q[l] <= {rqo_q[l][DW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q     <= '0;
      ratio_ok_q <= 1'b0;
    end else begin
      if (cmd_i.load) rcnt_q <= '0;
      else if (cmd_i.div_step) rcnt_q <= rcnt_q + 4'd1;
      if (cfg_hit) ratio_ok_q <= 1'b0;
      else if (div_done) ratio_ok_q <= 1'b1;
    end
  end

  // Committed frame position
  logic [bas_pkg::POS_W-1:0] src_col_q, src_row_q;
  logic [DW-1:0]             ccol_x_q, crow_y_q;
  bas_pkg::dda_t             ccol_q, crow_q;

  // Working position of the current transaction
  logic [DW-1:0]  wx_q, wy_q;
  bas_pkg::dda_t  wcol_q, wrow_q;
  logic [NW-1:0]  nfin_q, ny_q;
  logic [KW-1:0]  k_q;
  logic [DW-1:0]  colcnt_q [MAX_ENLARGE];
  logic [PW-1:0]  pr_q, pg_q, pb_q;
  logic           row_start_q, row_done_q;

  logic [DW-1:0] c_ext, r_ext;
  assign c_ext = {1'b0, src_col_q};
  assign r_ext = {1'b0, src_row_q};

  // Column span of wx
  bas_pkg::dda_t col_n;
  logic [DW-1:0] lo, hi;
  assign col_n = bas_pkg::dda_step(wcol_q, rqo_q[0], rr_q[0], dw_q);
  assign lo    = wcol_q.raw;
  assign hi    = (col_n.raw > lo) ? col_n.raw : lo + DW'(1);

  // Row span of wy and of wy+1
  bas_pkg::dda_t row_n, row_nn;
  logic [DW-1:0] top, bot, top1, bot1, rowcnt;
  logic          row_ok, row_next_ok;
  assign row_n  = bas_pkg::dda_step(wrow_q, rqo_q[1], rr_q[1], dh_q);
  assign row_nn = bas_pkg::dda_step(row_n, rqo_q[1], rr_q[1], dh_q);
  assign top    = wrow_q.raw;
  assign bot    = (row_n.raw > top) ? row_n.raw : top + DW'(1);
  assign top1   = row_n.raw;
  assign bot1   = (row_nn.raw > top1) ? row_nn.raw : top1 + DW'(1);
  assign rowcnt = bot - top;
  assign row_ok = (wy_q < dh_q) && (ny_q < NW'(MAX_ENLARGE)) && (top <= r_ext) &&
                  (bot == r_ext + DW'(1));
  assign row_next_ok = ((wy_q + DW'(1)) < dh_q) && ((ny_q + NW'(1)) < NW'(MAX_ENLARGE)) &&
                       (top1 <= r_ext) && (bot1 == r_ext + DW'(1));

  logic col_ok, col_fin, k_last;
  assign col_ok  = (wx_q < dw_q) && (nfin_q < NW'(MAX_ENLARGE)) && (c_ext >= lo) &&
                   (c_ext < hi);
  assign col_fin = (c_ext + DW'(1) == hi);
  assign k_last  = (NW'(k_q) + NW'(1) == nfin_q);

  // Sums memory: red, green, blue packed in one word
  logic [95:0]   mem [MAX_WIDTH];
  logic [95:0]   rdata_q;
  logic [DW:0]   x_wr_ext, x_em_ext;
  logic [DW-1:0] x_em;
  logic [95:0]   wdata;
  logic          fresh;
  assign x_em     = ccol_x_q + DW'(k_q);
  assign x_wr_ext = {1'b0, wx_q};
  assign x_em_ext = {1'b0, x_em};
  assign fresh    = row_start_q && (c_ext == lo);
  assign wdata    = fresh ? {24'd0, pr_q, 24'd0, pg_q, 24'd0, pb_q} :
                    {rdata_q[95:64] + 32'(pr_q), rdata_q[63:32] + 32'(pg_q),
                     rdata_q[31:0] + 32'(pb_q)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_wr) mem[x_wr_ext[AW-1:0]] <= wdata;
    if (cmd_i.col_rd) rdata_q <= mem[x_wr_ext[AW-1:0]];
    else if (cmd_i.em_rd) rdata_q <= mem[x_em_ext[AW-1:0]];
  end

  // Rounded average: 8 restoring steps, three channels in parallel
  logic [CW-1:0]  cnt_q;
  logic [NMW:0]   num_q [3];
  logic [NMW:0]   dsr_q;
  logic [PW-1:0]  quo_q [3];
  logic [2:0]     qcnt_q;
  logic [31:0]    sums [3];
  assign sums[0] = rdata_q[95:64];
  assign sums[1] = rdata_q[63:32];
  assign sums[2] = rdata_q[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.em_rd) cnt_q <= CW'(colcnt_q[k_q]) * CW'(rowcnt);
    if (cmd_i.q_start) begin
      dsr_q  <= (NMW+1)'(cnt_q) << (PW - 1);
      qcnt_q <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        num_q[ch] <= (NMW+1)'(sums[ch]) + (NMW+1)'(cnt_q >> 1);
      end
    end else if (cmd_i.q_step) begin
      dsr_q  <= dsr_q >> 1;
      qcnt_q <= qcnt_q + 3'd1;
      for (int ch = 0; ch < 3; ch++) begin
        if (num_q[ch] >= dsr_q) begin
          num_q[ch] <= num_q[ch] - dsr_q;
          quo_q[ch] <= {quo_q[ch][PW-2:0], 1'b1};
        end else begin
          quo_q[ch] <= {quo_q[ch][PW-2:0], 1'b0};
        end
      end
    end
  end

  // Working state and per-transaction captures
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pr_q   <= red_in_i;
      pg_q   <= green_in_i;
      pb_q   <= blue_in_i;
      wx_q   <= ccol_x_q;
      wcol_q <= ccol_q;
      wy_q   <= crow_y_q;
      wrow_q <= crow_q;
      nfin_q <= '0;
      ny_q   <= '0;
      k_q    <= '0;
    end
    if (cmd_i.rinit) begin
      row_start_q <= (wy_q < dh_q) && (r_ext == top);
      row_done_q  <= (wy_q < dh_q) && (r_ext + DW'(1) == bot);
    end
    if (cmd_i.col_wr && col_fin) begin
      colcnt_q[nfin_q[KW-1:0]] <= hi - lo;
      nfin_q <= nfin_q + NW'(1);
      wx_q   <= wx_q + DW'(1);
      wcol_q <= col_n;
    end
    if (cmd_i.row_adv) begin
      wy_q   <= wy_q + DW'(1);
      wrow_q <= row_n;
      ny_q   <= ny_q + NW'(1);
      k_q    <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + KW'(1);
    end
  end

  // Commit position at the end of the transaction; restart on config write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      ccol_x_q  <= '0;
      ccol_q    <= '0;
      crow_y_q  <= '0;
      crow_q    <= '0;
    end else if (cfg_hit) begin
      src_col_q <= '0;
      src_row_q <= '0;
      ccol_x_q  <= '0;
      ccol_q    <= '0;
      crow_y_q  <= '0;
      crow_q    <= '0;
    end else if (cmd_i.finish) begin
      if (c_ext + DW'(1) >= sw_q) begin
        src_col_q <= '0;
        ccol_x_q  <= '0;
        ccol_q    <= '0;
        if (r_ext + DW'(1) >= sh_q) begin
          src_row_q <= '0;
          crow_y_q  <= '0;
          crow_q    <= '0;
        end else begin
          src_row_q <= src_row_q + bas_pkg::POS_W'(1);
          if (row_done_q) begin
            crow_y_q <= wy_q;
            crow_q   <= wrow_q;
          end
        end
      end else begin
        src_col_q <= src_col_q + bas_pkg::POS_W'(1);
        ccol_x_q  <= wx_q;
        ccol_q    <= wcol_q;
      end
    end
  end

  // Result register
  logic out_free;
  assign out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.out_pix || cmd_i.out_err) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_pix) begin
      dst_x_o        <= x_em[bas_pkg::POS_W-1:0];
      dst_y_o        <= wy_q[bas_pkg::POS_W-1:0];
      red_out_o      <= quo_q[0];
      green_out_o    <= quo_q[1];
      blue_out_o     <= quo_q[2];
      alpha_out_o    <= bas_pkg::ALPHA_FULL;
      last_o         <= k_last && !row_next_ok;
      config_error_o <= 1'b0;
    end else if (cmd_i.out_err) begin
      dst_x_o        <= '0;
      dst_y_o        <= '0;
      red_out_o      <= '0;
      green_out_o    <= '0;
      blue_out_o     <= '0;
      alpha_out_o    <= '0;
      last_o         <= 1'b1;
      config_error_o <= 1'b1;
    end
  end

  assign sts_o.bad      = bad;
  assign sts_o.ratio_ok = ratio_ok_q;
  assign sts_o.div_done = div_done;
  assign sts_o.col_ok   = col_ok;
  assign sts_o.col_fin  = col_fin;
  assign sts_o.row_go   = row_done_q && row_ok;
  assign sts_o.has_fin  = (nfin_q != '0);
  assign sts_o.k_last   = k_last;
  assign sts_o.q_done   = (qcnt_q == 3'd7);
  assign sts_o.out_free = out_free;

endmodule

[hdl/box_average_image_scaler_top.sv]
// Top level of the box-average (area) image scaler.
// Source RGB pixels enter on the in_valid_i/in_ready_o channel in raster order,
// one transaction per pixel. Each destination pixel leaves on the out channel
// once the last source pixel of its box has arrived; an enlarged axis gives up
// to MAX_ENLARGE x MAX_ENLARGE results for one source pixel, last_o on the final
// one. A bad size setting answers every pixel with one config_error_o result.
// The four size registers are written on cfg_we_i; a write to any of them restarts the frame.
// Work per source pixel: a read-modify-write of the single-port sums memory for
// each destination column it touches, a check of each destination row, and per
// result a memory read, the product and the 8-step divider.
// The first pixel after a size write also runs the ratio divider.
// A stalled receiver holds the result register; the sequencer waits for it
// and takes no new pixel until the current one is done.
// Reset sets all sizes to 1, clears the frame position and empties the output.
// Sums memory contents are undefined after reset; every box starts with a write.
module box_average_image_scaler_top #(
  parameter int MAX_WIDTH   = bas_pkg::MAX_WIDTH,
  parameter int MAX_ENLARGE = bas_pkg::MAX_ENLARGE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bas_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bas_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bas_pkg::PIX_W-1:0]     red_in_i,
  input  logic [bas_pkg::PIX_W-1:0]     green_in_i,
  input  logic [bas_pkg::PIX_W-1:0]     blue_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bas_pkg::POS_W-1:0]     dst_x_o,
  output logic [bas_pkg::POS_W-1:0]     dst_y_o,
  output logic [bas_pkg::PIX_W-1:0]     red_out_o,
  output logic [bas_pkg::PIX_W-1:0]     green_out_o,
  output logic [bas_pkg::PIX_W-1:0]     blue_out_o,
  output logic [bas_pkg::PIX_W-1:0]     alpha_out_o,
  output logic                          last_o,
  output logic                          config_error_o
);

  bas_pkg::cmd_t    cmd;
  bas_pkg::status_t sts;

  bas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bas_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_ENLARGE (MAX_ENLARGE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dst_x_o        (dst_x_o),
    .dst_y_o        (dst_y_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .alpha_out_o    (alpha_out_o),
    .last_o         (last_o),
    .config_error_o (config_error_o)
  );

endmodule

[hdl/bas_checker.sv]
// Port-level checks of the box-average scaler, bound to the top level.
`include "box_average_image_scaler_top_defines.svh"

module bas_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [bas_pkg::POS_W-1:0] dst_x_o,
  input logic [bas_pkg::PIX_W-1:0] alpha_out_o,
  input logic                      last_o,
  input logic                      config_error_o
);

  // An error transaction carries no pixel and closes its input.
  `BAS_ASSERT_NOW(a_err_shape, out_valid_o && config_error_o, last_o && alpha_out_o == '0)

  // A pixel transaction is opaque.
  `BAS_ASSERT_NOW(a_pix_alpha, out_valid_o && !config_error_o,
                  alpha_out_o == bas_pkg::ALPHA_FULL)

  // Hold a stalled result.
  `BAS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(dst_x_o) && $stable(last_o))

endmodule

bind box_average_image_scaler_top bas_checker u_bas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .dst_x_o        (dst_x_o),
  .alpha_out_o    (alpha_out_o),
  .last_o         (last_o),
  .config_error_o (config_error_o)
);
